// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/dnp_pkg.sv -----
// Shared types and constants of the duration number parser.
// No dependencies; imported by every parser module.
`default_nettype none

package dnp_pkg;

  // character classes passed from the front to the back
  localparam logic [2:0] CLS_DIGIT = 3'd0;
  localparam logic [2:0] CLS_PLUS  = 3'd1;
  localparam logic [2:0] CLS_MINUS = 3'd2;
  localparam logic [2:0] CLS_DOT   = 3'd3;
  localparam logic [2:0] CLS_COLON = 3'd4;
  localparam logic [2:0] CLS_OTHER = 3'd5;

  // time_kind register codes, also the kind field of time results
  localparam logic [1:0] TK_NONE = 2'd0;
  localparam logic [1:0] TK_DUR  = 2'd1;
  localparam logic [1:0] TK_DEC  = 2'd2;

  // register indexes
  localparam logic REG_ALLOW_INTEGER = 1'b0;
  localparam logic REG_TIME_KIND     = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INT     = 2'd1;
  localparam logic [1:0] ERR_TIME    = 2'd2;
  localparam logic [1:0] ERR_NO_TYPE = 2'd3;

  localparam logic [30:0] VAL_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0] HOUR_MAX = 31'd596523;
  localparam logic [30:0] MIN_MAX  = 31'd35791394;
  localparam int unsigned FRACTION_DIGITS = 6;

  typedef struct packed {
    logic       first;
    logic [2:0] cls;
    logic [3:0] digit;
  } tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/duration_number_parser.sv -----
// Top level of the streaming decimal integer and duration parser.
// Depends on dnp_pkg, dnp_front, dnp_queue and dnp_back.
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_stall    ch, first
//  out      out  out_valid / out_stall  seconds, microseconds, kind, hms_form, error, consumed
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One character per cycle is taken while the queue has room; the back end retires one
// queued character per cycle whenever the result register is empty or being drained.
// A result is registered and appears in the cycle after its terminating character is popped
// from the queue; with an empty queue a character passes a queue slot and the result register.
// Reset is synchronous and clears the queue, parser phase, result valid and time_kind; it sets allow_integer.
// A stall on the output backs up through the QUEUE_DEPTH entry queue to in_stall.
`default_nettype none

module duration_number_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic               first,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] seconds,
  output logic signed [20:0] microseconds,
  output logic [1:0]         kind,
  output logic               hms_form,
  output logic [1:0]         error,
  output logic [15:0]        consumed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);
  import dnp_pkg::*;

  logic       allow_integer;
  logic [1:0] time_kind;
  logic       q_full;
  logic       q_push;
  tok_t       front_tok;
  logic       q_valid;
  tok_t       q_tok;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_integer <= 1'b1;
      time_kind     <= TK_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALLOW_INTEGER: allow_integer <= cfg_data[0];
        REG_TIME_KIND:     time_kind     <= cfg_data;
        default:           allow_integer <= allow_integer;
      endcase
    end
  end

  dnp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .first    (first),
    .q_full   (q_full),
    .push     (q_push),
    .tok      (front_tok)
  );

  dnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .tok_in  (front_tok),
    .full    (q_full),
    .valid   (q_valid),
    .tok_out (q_tok),
    .pop     (q_pop)
  );

  dnp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_tok         (q_tok),
    .q_pop         (q_pop),
    .allow_integer (allow_integer),
    .time_kind     (time_kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .seconds       (seconds),
    .microseconds  (microseconds),
    .kind          (kind),
    .hms_form      (hms_form),
    .error         (error),
    .consumed      (consumed)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dnp_front.sv -----
// Front end: takes characters and classifies them into queue requests.
// Depends on dnp_pkg.
`default_nettype none

module dnp_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    ch,
  input  logic          first,
  input  logic          q_full,
  output logic          push,
  output dnp_pkg::tok_t tok
);
  import dnp_pkg::*;

  logic is_num;

  assign is_num   = (ch >= 8'h30) && (ch <= 8'h39);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    tok.first = first;
    // '0'..'9' sit at 0x30..0x39, so the low nibble is the digit value
    tok.digit = ch[3:0];
    if (is_num) begin
      tok.cls = CLS_DIGIT;
    end else begin
      unique case (ch)
        8'h2B:   tok.cls = CLS_PLUS;
        8'h2D:   tok.cls = CLS_MINUS;
        8'h2E:   tok.cls = CLS_DOT;
        8'h3A:   tok.cls = CLS_COLON;
        default: tok.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dnp_queue.sv -----
// Short request queue between the parser front and back.
// Depends on dnp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dnp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dnp_pkg::tok_t tok_in,
  output logic          full,
  output logic          valid,
  output dnp_pkg::tok_t tok_out,
  input  logic          pop
);
  import dnp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign tok_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_CLK(a_no_pop_empty, clk, rst, pop |-> (count != '0), "pop from empty queue")
  `ASSERT_CLK(a_no_push_full, clk, rst, push |-> (count != CW'(DEPTH)), "push into full queue")

endmodule

`default_nettype wire

// ----- hw/rtl/dnp_back.sv -----
// Back end: parser state machine and result register.
// Depends on dnp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dnp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dnp_pkg::tok_t      q_tok,
  output logic               q_pop,
  input  logic               allow_integer,
  input  logic [1:0]         time_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] seconds,
  output logic signed [20:0] microseconds,
  output logic [1:0]         kind,
  output logic               hms_form,
  output logic [1:0]         error,
  output logic [15:0]        consumed
);
  import dnp_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SIGN      = 3'd1;
  localparam logic [2:0] PH_WHOLE     = 3'd2;
  localparam logic [2:0] PH_MIN_START = 3'd3;
  localparam logic [2:0] PH_MIN       = 3'd4;
  localparam logic [2:0] PH_SEC_START = 3'd5;
  localparam logic [2:0] PH_SEC       = 3'd6;
  localparam logic [2:0] PH_FRAC      = 3'd7;

  // acc * 10 + digit, clamped; bit 31 flags the clamp
  function automatic logic [31:0] add10(input logic [30:0] acc, input logic [3:0] dg);
    logic [34:0] v;
    begin
      v = 35'(acc) * 35'd10 + 35'(dg);
      if (v > 35'(VAL_MAX)) begin
        add10 = {1'b1, VAL_MAX};
      end else begin
        add10 = {1'b0, v[30:0]};
      end
    end
  endfunction

  // scale for padding the fraction out to six digits
  function automatic logic [19:0] pad_scale(input logic [2:0] n);
    begin
      unique case (n)
        3'd0:    pad_scale = 20'd1000000;
        3'd1:    pad_scale = 20'd100000;
        3'd2:    pad_scale = 20'd10000;
        3'd3:    pad_scale = 20'd1000;
        3'd4:    pad_scale = 20'd100;
        3'd5:    pad_scale = 20'd10;
        default: pad_scale = 20'd1;
      endcase
    end
  endfunction

  // stored state
  logic [2:0]  phase;
  logic        negative;
  logic [30:0] whole_accum;
  logic [30:0] field_accum;
  logic        saturated;
  logic [19:0] usec_accum;
  logic [2:0]  frac_digits;
  logic [15:0] char_count;
  logic        hms_seen;

  // state seen by this request (cleared on first, with the phase starting at PH_SIGN)
  logic [2:0]  ph;
  logic        neg;
  logic [30:0] wh;
  logic [30:0] fa;
  logic        sat;
  logic [19:0] us;
  logic [2:0]  fd;
  logic [15:0] cc;
  logic        hs;

  logic [2:0]  phase_next;
  logic        negative_next;
  logic [30:0] whole_accum_next;
  logic [30:0] field_accum_next;
  logic        saturated_next;
  logic [19:0] usec_accum_next;
  logic [2:0]  frac_digits_next;
  logic [15:0] char_count_next;
  logic        hms_seen_next;

  logic [1:0]  tk_eff;
  logic        is_num;
  logic        is_dot;
  logic        is_colon;
  logic [31:0] ad_whole;
  logic [31:0] ad_field;
  logic [42:0] hour_prod;
  logic [37:0] min_sum;
  logic [31:0] sec_sum;
  logic [39:0] pad_prod;
  logic [23:0] frac_step;

  logic        do_consume;
  logic        do_whole_end;
  logic        do_dot_end;
  logic        emit;
  logic [30:0] e_sec;
  logic [19:0] e_us;
  logic [1:0]  e_kind;
  logic [1:0]  e_err;

  // result register
  logic [30:0] o_sec;
  logic [19:0] o_us;
  logic        o_neg;
  logic [1:0]  o_kind;
  logic        o_hms;
  logic [1:0]  o_err;
  logic [15:0] o_cnt;

  assign tk_eff   = (time_kind == TK_DUR || time_kind == TK_DEC) ? time_kind : TK_NONE;
  assign is_num   = (q_tok.cls == CLS_DIGIT);
  assign is_dot   = (q_tok.cls == CLS_DOT);
  assign is_colon = (q_tok.cls == CLS_COLON);
  assign q_pop    = q_valid && (!out_valid || !out_stall);

  always_comb begin
    if (q_tok.first) begin
      ph  = PH_SIGN;
      neg = 1'b0;
      wh  = '0;
      fa  = '0;
      sat = 1'b0;
      us  = '0;
      fd  = '0;
      cc  = '0;
      hs  = 1'b0;
    end else begin
      ph  = phase;
      neg = negative;
      wh  = whole_accum;
      fa  = field_accum;
      sat = saturated;
      us  = usec_accum;
      fd  = frac_digits;
      cc  = char_count;
      hs  = hms_seen;
    end

    ad_whole  = add10(wh, q_tok.digit);
    ad_field  = add10(fa, q_tok.digit);
    hour_prod = 43'(wh) * 43'd3600;
    min_sum   = 38'(wh) + 38'(fa) * 38'd60;
    sec_sum   = 32'(wh) + 32'(fa);
    pad_prod  = 40'(us) * 40'(pad_scale(fd));
    frac_step = 24'(us) * 24'd10 + 24'(q_tok.digit);

    phase_next       = ph;
    negative_next    = neg;
    whole_accum_next = wh;
    field_accum_next = fa;
    saturated_next   = sat;
    usec_accum_next  = us;
    frac_digits_next = fd;
    hms_seen_next    = hs;

    do_consume   = 1'b0;
    do_whole_end = 1'b0;
    do_dot_end   = 1'b0;
    emit         = 1'b0;
    e_sec        = '0;
    e_us         = '0;
    e_kind       = tk_eff;
    e_err        = ERR_NONE;

    unique case (ph)
      PH_IDLE: begin
      end
      PH_SIGN: begin
        if (q_tok.cls == CLS_PLUS || q_tok.cls == CLS_MINUS) begin
          if (q_tok.cls == CLS_MINUS) begin
            negative_next = ~neg;
          end
          do_consume = 1'b1;
        end else if (!allow_integer && tk_eff == TK_NONE) begin
          emit   = 1'b1;
          e_kind = TK_NONE;
          e_err  = ERR_NO_TYPE;
        end else if (is_num) begin
          whole_accum_next = ad_whole[30:0];
          saturated_next   = sat | ad_whole[31];
          do_consume       = 1'b1;
          phase_next       = PH_WHOLE;
        end else begin
          do_whole_end = 1'b1;
        end
      end
      PH_WHOLE: begin
        if (is_num) begin
          whole_accum_next = ad_whole[30:0];
          saturated_next   = sat | ad_whole[31];
          do_consume       = 1'b1;
        end else begin
          do_whole_end = 1'b1;
        end
      end
      PH_MIN_START, PH_SEC_START: begin
        if (is_num) begin
          saturated_next   = 1'b0;
          field_accum_next = 31'(q_tok.digit);
          do_consume       = 1'b1;
          phase_next       = (ph == PH_MIN_START) ? PH_MIN : PH_SEC;
        end else begin
          do_dot_end = 1'b1;
        end
      end
      PH_MIN: begin
        if (is_num) begin
          field_accum_next = ad_field[30:0];
          saturated_next   = sat | ad_field[31];
          do_consume       = 1'b1;
        end else if (fa > MIN_MAX || min_sum > 38'(VAL_MAX)) begin
          emit  = 1'b1;
          e_err = ERR_TIME;
        end else begin
          whole_accum_next = min_sum[30:0];
          if (is_colon) begin
            do_consume = 1'b1;
            phase_next = PH_SEC_START;
          end else begin
            do_dot_end = 1'b1;
          end
        end
      end
      PH_SEC: begin
        if (is_num) begin
          field_accum_next = ad_field[30:0];
          saturated_next   = sat | ad_field[31];
          do_consume       = 1'b1;
        end else if (sat || sec_sum > 32'(VAL_MAX)) begin
          emit  = 1'b1;
          e_err = ERR_TIME;
        end else begin
          whole_accum_next = sec_sum[30:0];
          do_dot_end       = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_num) begin
          // keep the leading digits, skip the rest
          if (32'(fd) < FRACTION_DIGITS) begin
            usec_accum_next  = frac_step[19:0];
            frac_digits_next = fd + 3'd1;
          end
          do_consume = 1'b1;
        end else begin
          emit  = 1'b1;
          e_sec = wh;
          e_us  = pad_prod[19:0];
        end
      end
      default: begin
      end
    endcase

    if (do_whole_end) begin
      if (allow_integer && !(tk_eff != TK_NONE && (is_dot || is_colon))) begin
        emit   = 1'b1;
        e_kind = TK_NONE;
        e_err  = sat ? ERR_INT : ERR_NONE;
        e_sec  = sat ? '0 : wh;
      end else if (is_colon) begin
        hms_seen_next = 1'b1;
        if (wh > HOUR_MAX) begin
          emit  = 1'b1;
          e_err = ERR_TIME;
        end else begin
          whole_accum_next = hour_prod[30:0];
          do_consume       = 1'b1;
          phase_next       = PH_MIN_START;
        end
      end else if (sat) begin
        emit  = 1'b1;
        e_err = ERR_TIME;
      end else begin
        do_dot_end = 1'b1;
      end
    end

    if (do_dot_end) begin
      if (is_dot) begin
        do_consume       = 1'b1;
        usec_accum_next  = '0;
        frac_digits_next = '0;
        phase_next       = PH_FRAC;
      end else begin
        emit  = 1'b1;
        e_sec = whole_accum_next;
      end
    end

    if (emit) begin
      phase_next = PH_IDLE;
    end
    char_count_next = (do_consume && cc != 16'hFFFF) ? cc + 16'd1 : cc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (q_pop) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      negative    <= negative_next;
      whole_accum <= whole_accum_next;
      field_accum <= field_accum_next;
      saturated   <= saturated_next;
      usec_accum  <= usec_accum_next;
      frac_digits <= frac_digits_next;
      char_count  <= char_count_next;
      hms_seen    <= hms_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      o_sec  <= e_sec;
      o_us   <= e_us;
      o_neg  <= negative_next;
      o_kind <= e_kind;
      o_hms  <= hms_seen_next;
      o_err  <= e_err;
      o_cnt  <= cc;
    end
  end

  // apply the sign on the way out
  assign seconds      = o_neg ? (32'd0 - {1'b0, o_sec}) : {1'b0, o_sec};
  assign microseconds = o_neg ? (21'd0 - {1'b0, o_us}) : {1'b0, o_us};
  assign kind         = o_kind;
  assign hms_form     = o_hms;
  assign error        = o_err;
  assign consumed     = o_cnt;

  `ASSERT_CLK(a_emit_idle, clk, rst,
    (q_pop && emit) |=> (phase == PH_IDLE),
    "no idle after result")
  `ASSERT_CLK(a_frac_bound, clk, rst,
    (32'(frac_digits) <= FRACTION_DIGITS) || (phase != PH_FRAC),
    "fraction digit count too high")
  `ASSERT_CLK(a_usec_range, clk, rst,
    out_valid |-> (o_us < 20'd1000000),
    "microseconds out of range")
  `ASSERT_CLK(a_err_zero, clk, rst,
    (out_valid && o_err != ERR_NONE) |-> (o_sec == '0 && o_us == '0),
    "error result carries a value")

endmodule

`default_nettype wire
